// File: src/etp_pkg.sv
// Package with shared widths, reset values, register indexes and display tables.
`timescale 1ns / 1ps

package etp_pkg;

  localparam int FREQ_W     = 14;
  localparam int STEP_W     = 10;
  localparam int VOL_W      = 16;
  localparam int ENC_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int SEG_W      = 8;
  localparam int CODE_W     = 3;
  localparam int DIGITS     = 4;
  localparam int POS_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [FREQ_W-1:0] FREQ_LOW_RST  = 14'd8810;
  localparam logic [FREQ_W-1:0] FREQ_HIGH_RST = 14'd10790;
  localparam logic [STEP_W-1:0] FREQ_STEP_RST = 10'd20;
  localparam logic [VOL_W-1:0]  VOL_STEP_RST  = 16'h1000;
  localparam logic [VOL_W-1:0]  VOL_MAX_RST   = 16'hF000;
  localparam logic [FREQ_W-1:0] FREQ_RST      = 14'd8810;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_MAX   = 3'd4;

  localparam logic [ENC_W-1:0] ENC_PHASE_A = 2'b10;
  localparam logic [ENC_W-1:0] ENC_PHASE_B = 2'b00;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
  localparam logic [SEG_W-1:0] DP_MASK   = 8'h7F;

  localparam logic [CODE_W-1:0] CODE_POS1 = 3'd1;

  // Reciprocal multipliers; each quotient is exact for every 14-bit value.
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          SHIFT_10    = 19;
  localparam logic [15:0] RECIP_100   = 16'd5243;
  localparam int          SHIFT_100   = 19;
  localparam logic [15:0] RECIP_1000  = 16'd16778;
  localparam int          SHIFT_1000  = 24;
  localparam logic [15:0] RECIP_10000 = 16'd13422;
  localparam int          SHIFT_10000 = 27;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_CW,
    DIR_CCW
  } dir_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  vol;
    logic              retune;
    logic [POS_W-1:0]  pos;
  } etp_stage_t;

  function automatic dir_t enc_dir(input logic [ENC_W-1:0] prev,
                                   input logic [ENC_W-1:0] cur,
                                   input logic             vld);
    dir_t d;
    d = DIR_NONE;
    if (vld && prev == ENC_PHASE_A && cur == ENC_PHASE_B) begin
      d = DIR_CW;
    end else if (vld && prev == ENC_PHASE_B && cur == ENC_PHASE_A) begin
      d = DIR_CCW;
    end
    return d;
  endfunction

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] s;
    case (digit)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] digit_select(input logic [POS_W-1:0] pos);
    logic [CODE_W-1:0] c;
    case (pos)
      2'd0:    c = 3'd0;
      2'd1:    c = CODE_POS1;
      2'd2:    c = 3'd3;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

endpackage

// File: src/etp_if.sv
// Channel interfaces for the panel input, the display result and the register writes.
`timescale 1ns / 1ps

interface etp_in_if;
  import etp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] panel_byte;
  modport source (output valid, output panel_byte, input ready);
  modport sink (input valid, input panel_byte, output ready);
endinterface

interface etp_out_if;
  import etp_pkg::*;
  logic              valid;
  logic              ready;
  logic [SEG_W-1:0]  segments;
  logic [CODE_W-1:0] digit_code;
  logic [FREQ_W-1:0] frequency;
  logic [VOL_W-1:0]  volume_level;
  logic              retune;
  modport source (output valid, output segments, output digit_code, output frequency,
                  output volume_level, output retune, input ready);
  modport sink (input valid, input segments, input digit_code, input frequency,
                input volume_level, input retune, output ready);
endinterface

interface etp_cfg_if;
  import etp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/encoder_tuner_panel.sv
// Top level of the tuner panel: encoder decoding, tuning and volume state, display scan.
//
//  Channel  Dir  Contents
//  in_ch    in   panel_byte: tuning encoder in bits 1:0, volume encoder in bits 3:2
//  out_ch   out  segments, digit_code, frequency, volume_level, retune
//  cfg_ch   in   index and data of a register write, always ready
//
// One transaction is accepted per clock while the stage can advance; the result
// is registered in the stage and then in the output registers. Tuning, volume
// and scan state update at the input edge, and the digit extraction (four constant
// reciprocal multiplies) runs in the next stage. A stalled output holds its result
// while one more transaction waits in the stage. Reset is synchronous and active
// low and restores the registers, the panel state and the valid flags.
`timescale 1ns / 1ps

module encoder_tuner_panel
  import etp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  etp_in_if.sink    in_ch,
  etp_out_if.source out_ch,
  etp_cfg_if.sink   cfg_ch
);

  logic [FREQ_W-1:0] freq_low_r;
  logic [FREQ_W-1:0] freq_high_r;
  logic [STEP_W-1:0] freq_step_r;
  logic [VOL_W-1:0]  vol_step_r;
  logic [VOL_W-1:0]  vol_max_r;

  logic [ENC_W-1:0]  tune_prev_r;
  logic              tune_vld_r;
  logic [ENC_W-1:0]  vol_prev_r;
  logic              vol_vld_r;
  logic [FREQ_W-1:0] freq_r;
  logic [VOL_W-1:0]  vol_r;
  logic [POS_W-1:0]  scan_r;

  logic              s1_v_r;
  etp_stage_t        s1_r;
  etp_stage_t        s1_nxt;
  logic              out_v_r;
  logic [SEG_W-1:0]  seg_r;
  logic [SEG_W-1:0]  seg_nxt;
  logic [CODE_W-1:0] code_r;
  logic [FREQ_W-1:0] ofreq_r;
  logic [VOL_W-1:0]  ovol_r;
  logic              oretune_r;

  logic              in_fire;
  logic              cfg_fire;
  logic              adv;
  logic [ENC_W-1:0]  tune_cur;
  logic [ENC_W-1:0]  vol_cur;
  dir_t              tune_dir;
  dir_t              vol_dir;
  logic [FREQ_W:0]   freq_sum;
  logic [FREQ_W-1:0] freq_diff;
  logic [FREQ_W-1:0] freq_nxt;
  logic [VOL_W:0]    vol_sum;
  logic [VOL_W-1:0]  vol_dec;
  logic [VOL_W-1:0]  vol_nxt;

  logic [10:0]       q1;
  logic [7:0]        q2;
  logic [4:0]        q3;
  logic              q4;
  logic [3:0]        dig0;
  logic [3:0]        dig1;
  logic [3:0]        dig2;
  logic [3:0]        dig3;
  logic [3:0]        dig_sel;
  logic              lit;

  assign adv       = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire  = cfg_ch.valid && cfg_ch.ready;

  assign tune_cur = in_ch.panel_byte[1:0];
  assign vol_cur  = in_ch.panel_byte[3:2];
  assign tune_dir = enc_dir(tune_prev_r, tune_cur, tune_vld_r);
  assign vol_dir  = enc_dir(vol_prev_r, vol_cur, vol_vld_r);

  always_comb begin
    freq_sum  = {1'b0, freq_r} + (FREQ_W + 1)'(freq_step_r);
    freq_diff = freq_r - FREQ_W'(freq_step_r);
    freq_nxt  = freq_r;
    case (tune_dir)
      DIR_CW: begin
        freq_nxt = (freq_sum > {1'b0, freq_high_r}) ? freq_low_r : freq_sum[FREQ_W-1:0];
      end
      DIR_CCW: begin
        if (freq_r < FREQ_W'(freq_step_r) || freq_diff < freq_low_r) begin
          freq_nxt = freq_high_r;
        end else begin
          freq_nxt = freq_diff;
        end
      end
      default: freq_nxt = freq_r;
    endcase
  end

  always_comb begin
    vol_sum = {1'b0, vol_r} + {1'b0, vol_step_r};
    vol_dec = (vol_r < vol_step_r) ? '0 : vol_r - vol_step_r;
    vol_nxt = vol_r;
    case (vol_dir)
      DIR_CW:  vol_nxt = (vol_dec > vol_max_r) ? vol_max_r : vol_dec;
      DIR_CCW: vol_nxt = (vol_sum > {1'b0, vol_max_r}) ? vol_max_r : vol_sum[VOL_W-1:0];
      default: vol_nxt = vol_r;
    endcase
  end

  always_comb begin
    s1_nxt.freq   = freq_nxt;
    s1_nxt.vol    = vol_nxt;
    s1_nxt.retune = (tune_dir != DIR_NONE) || (vol_dir != DIR_NONE);
    s1_nxt.pos    = scan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_low_r  <= FREQ_LOW_RST;
      freq_high_r <= FREQ_HIGH_RST;
      freq_step_r <= FREQ_STEP_RST;
      vol_step_r  <= VOL_STEP_RST;
      vol_max_r   <= VOL_MAX_RST;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        REG_FREQ_LOW:  freq_low_r  <= cfg_ch.data[FREQ_W-1:0];
        REG_FREQ_HIGH: freq_high_r <= cfg_ch.data[FREQ_W-1:0];
        REG_FREQ_STEP: freq_step_r <= cfg_ch.data[STEP_W-1:0];
        REG_VOL_STEP:  vol_step_r  <= cfg_ch.data[VOL_W-1:0];
        REG_VOL_MAX:   vol_max_r   <= cfg_ch.data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tune_prev_r <= '0;
      tune_vld_r  <= 1'b1;
      vol_prev_r  <= '0;
      vol_vld_r   <= 1'b1;
      freq_r      <= FREQ_RST;
      vol_r       <= '0;
      scan_r      <= '0;
    end else if (in_fire) begin
      if (tune_dir != DIR_NONE) begin
        tune_vld_r <= 1'b0;
      end else begin
        tune_prev_r <= tune_cur;
        tune_vld_r  <= 1'b1;
      end
      if (vol_dir != DIR_NONE) begin
        vol_vld_r <= 1'b0;
      end else begin
        vol_prev_r <= vol_cur;
        vol_vld_r  <= 1'b1;
      end
      freq_r <= freq_nxt;
      vol_r  <= vol_nxt;
      scan_r <= scan_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    q1 = 11'((32'(s1_r.freq) * 32'(RECIP_10)) >> SHIFT_10);
    q2 = 8'((32'(s1_r.freq) * 32'(RECIP_100)) >> SHIFT_100);
    q3 = 5'((32'(s1_r.freq) * 32'(RECIP_1000)) >> SHIFT_1000);
    q4 = 1'((32'(s1_r.freq) * 32'(RECIP_10000)) >> SHIFT_10000);
    dig0 = 4'(q1 - 11'(q2) * 11'd10);
    dig1 = 4'(q2 - 8'(q3) * 8'd10);
    dig2 = 4'(q3 - 5'(q4) * 5'd10);
    dig3 = 4'(q4);
    case (s1_r.pos)
      2'd0: begin
        dig_sel = dig0;
        lit     = 1'b1;
      end
      2'd1: begin
        dig_sel = dig1;
        lit     = (q2 != '0);
      end
      2'd2: begin
        dig_sel = dig2;
        lit     = (q3 != '0);
      end
      default: begin
        dig_sel = dig3;
        lit     = q4;
      end
    endcase
    if (!lit) begin
      seg_nxt = SEG_BLANK;
    end else if (s1_r.pos == 2'd1) begin
      seg_nxt = seg_pattern(dig_sel) & DP_MASK;
    end else begin
      seg_nxt = seg_pattern(dig_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      seg_r     <= seg_nxt;
      code_r    <= digit_select(s1_r.pos);
      ofreq_r   <= s1_r.freq;
      ovol_r    <= s1_r.vol;
      oretune_r <= s1_r.retune;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.digit_code   = code_r;
  assign out_ch.frequency    = ofreq_r;
  assign out_ch.volume_level = ovol_r;
  assign out_ch.retune       = oretune_r;

  // A tuning detent must suppress the next tuning sample.
  a_tune_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && tune_dir != DIR_NONE |=> !tune_vld_r)
    else $error("tuning detent did not invalidate the previous sample");

  // The scan position advances by one with every accepted transaction.
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> scan_r == POS_W'($past(scan_r) + POS_W'(1)))
    else $error("scan position did not advance");

  // A staged transaction is never dropped while the output is stalled.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_r))
    else $error("staged transaction lost during a stall");

  // The decimal point is only lit on the second digit position.
  a_dp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.segments[SEG_W-1] |-> out_ch.digit_code == CODE_POS1)
    else $error("decimal point on the wrong digit");

endmodule
